FILE: rtl/mqllm_pkg.sv
// Shared constants for the multi-queue linked-list manager: field widths,
// status and operation codes, and default sizes. No dependencies.
package mqllm_pkg;

    localparam int QUEUE_COUNT_DEF = 64;
    localparam int NODE_COUNT_DEF  = 1024;

    localparam int QID_W     = 6;
    localparam int ADDR_W    = 48;
    localparam int CFG_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 96;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADID = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

endpackage

FILE: rtl/multi_queue_linked_list_manager.sv
// Top level of the multi-queue linked-list manager: stream ports, control
// sequencer, free list, and the node link and entry RAMs.
// Uses mqllm_pkg, mqllm_ram and mqllm_queue_table.

// Up to QUEUE_COUNT FIFO queues of (address, size) entries share a pool of
// NODE_COUNT nodes kept as linked lists. An enqueue passes S_IDLE and S_LOOK,
// and a successful dequeue also S_FINISH: each step waits on the registered read
// of the queue table and then of the node RAMs, and items are processed one at a time.
// Refused items (bad id, empty queue, full pool) finish in S_LOOK. A finished
// result sits in an output register, so the next item is taken while it
// waits; the block stalls only when a second result is ready before the
// first has gone. Every item gives exactly one result. No clearing pass is
// needed after reset.
module multi_queue_linked_list_manager #(
    parameter int QUEUE_COUNT = mqllm_pkg::QUEUE_COUNT_DEF,
    parameter int NODE_COUNT  = mqllm_pkg::NODE_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mqllm_pkg::CFG_W-1:0]        cfg_wdata,  // active_queues
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mqllm_pkg::IN_DATA_W-1:0]    s_tdata,    // queue_id, map_address, map_size, pad
    input  logic [0:0]                         s_tuser,    // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mqllm_pkg::OUT_DATA_W-1:0]   m_tdata,    // out_address, out_size
    output logic [mqllm_pkg::STATUS_W-1:0]     m_tuser     // status
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam int AW = mqllm_pkg::ADDR_W;
    localparam int QIDW = mqllm_pkg::QID_W;
    localparam logic [LW-1:0] LINK_NULL = LW'(NODE_COUNT);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic                               op_reg;
    logic [QIDW-1:0]                    qid_reg;
    logic [AW-1:0]                      addr_reg;
    logic [AW-1:0]                      size_reg;
    logic [mqllm_pkg::STATUS_W-1:0]     pre_reg;
    logic [mqllm_pkg::STATUS_W-1:0]     pre_next;
    logic                               ne_reg;

    logic [LW-1:0] free_head_reg;
    logic [LW-1:0] free_head_next;
    logic [LW-1:0] nodes_reached_reg;
    logic [LW-1:0] nodes_reached_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [mqllm_pkg::STATUS_W-1:0] out_status_reg;
    logic [mqllm_pkg::STATUS_W-1:0] out_status_next;
    logic [AW-1:0]                  out_addr_reg;
    logic [AW-1:0]                  out_addr_next;
    logic [AW-1:0]                  out_size_reg;
    logic [AW-1:0]                  out_size_next;

    logic            in_op;
    logic [QIDW-1:0] in_qid;
    logic [AW-1:0]   in_addr;
    logic [AW-1:0]   in_size;
    logic            accept;
    logic            out_free;

    logic          id_ok;
    logic          nonempty;
    logic          q_rd_en;
    logic [NW-1:0] q_front;
    logic [NW-1:0] q_back;
    logic          q_wr_en;
    logic [NW-1:0] q_wr_front;
    logic [NW-1:0] q_wr_back;
    logic          flag_set;
    logic          flag_clr;

    logic          free_valid;
    logic [NW-1:0] n_enq;
    logic          link_re;
    logic [NW-1:0] link_raddr;
    logic [LW-1:0] link_rdata;
    logic [LW-1:0] link_clamped;
    logic          link_we;
    logic [NW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic          data_re;
    logic          data_we;
    logic [NW-1:0] data_waddr;
    logic [2*AW-1:0] data_rdata;

    assign in_op   = s_tuser[0];
    assign in_qid  = s_tdata[QIDW-1:0];
    assign in_addr = s_tdata[QIDW +: AW];
    assign in_size = s_tdata[QIDW + AW +: AW];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_size_reg, out_addr_reg};

    assign free_valid   = (free_head_reg < LINK_NULL);
    assign n_enq        = free_valid ? free_head_reg[NW-1:0] : nodes_reached_reg[NW-1:0];
    assign link_clamped = (link_rdata < LINK_NULL) ? link_rdata : LINK_NULL;

    mqllm_queue_table #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .NW          (NW)
    ) u_queues (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .lookup_qid (s_tready ? in_qid : qid_reg),
        .id_ok      (id_ok),
        .nonempty   (nonempty),
        .rd_en      (q_rd_en),
        .rd_front   (q_front),
        .rd_back    (q_back),
        .wr_qid     (qid_reg),
        .wr_en      (q_wr_en),
        .wr_front   (q_wr_front),
        .wr_back    (q_wr_back),
        .flag_set   (flag_set),
        .flag_clr   (flag_clr)
    );

    // Next links; free nodes chain through the same field.
    mqllm_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (LW),
        .AW    (NW)
    ) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Stored entries, size in the upper half.
    mqllm_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (2 * AW),
        .AW    (NW)
    ) u_entries (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata ({size_reg, addr_reg}),
        .re    (data_re),
        .raddr (q_front),
        .rdata (data_rdata)
    );

    always_comb
    begin
        if (!id_ok)
        begin
            pre_next = mqllm_pkg::ST_BADID;
        end
        else if (in_op == mqllm_pkg::OP_DEQ && !nonempty)
        begin
            pre_next = mqllm_pkg::ST_EMPTY;
        end
        else if (in_op == mqllm_pkg::OP_ENQ && !free_valid
                 && nodes_reached_reg == LINK_NULL)
        begin
            pre_next = mqllm_pkg::ST_FULL;
        end
        else
        begin
            pre_next = mqllm_pkg::ST_OK;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        free_head_next     = free_head_reg;
        nodes_reached_next = nodes_reached_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_status_next    = out_status_reg;
        out_addr_next      = out_addr_reg;
        out_size_next      = out_size_reg;
        q_rd_en            = 1'b0;
        q_wr_en            = 1'b0;
        q_wr_front         = q_front;
        q_wr_back          = q_back;
        flag_set           = 1'b0;
        flag_clr           = 1'b0;
        link_re            = 1'b0;
        link_raddr         = free_head_reg[NW-1:0];
        link_we            = 1'b0;
        link_waddr         = q_back;
        link_wdata         = LW'(n_enq);
        data_re            = 1'b0;
        data_we            = 1'b0;
        data_waddr         = n_enq;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    // Fetch the queue ends and the link after the free head.
                    q_rd_en    = 1'b1;
                    link_re    = free_valid;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (pre_reg != mqllm_pkg::ST_OK)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = pre_reg;
                        out_addr_next   = '0;
                        out_size_next   = '0;
                        state_next      = S_IDLE;
                    end
                end
                else if (op_reg == mqllm_pkg::OP_ENQ)
                begin
                    if (out_free)
                    begin
                        data_we = 1'b1;
                        q_wr_en = 1'b1;
                        if (ne_reg)
                        begin
                            link_we   = 1'b1;
                            q_wr_back = n_enq;
                        end
                        else
                        begin
                            q_wr_front = n_enq;
                            q_wr_back  = n_enq;
                            flag_set   = 1'b1;
                        end
                        if (free_valid)
                        begin
                            free_head_next = link_clamped;
                        end
                        else
                        begin
                            nodes_reached_next = nodes_reached_reg + LW'(1);
                        end
                        out_valid_next  = 1'b1;
                        out_status_next = mqllm_pkg::ST_OK;
                        out_addr_next   = '0;
                        out_size_next   = '0;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    link_re    = 1'b1;
                    link_raddr = q_front;
                    data_re    = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    if (q_front == q_back || link_clamped == LINK_NULL)
                    begin
                        flag_clr = 1'b1;
                    end
                    else
                    begin
                        q_wr_en    = 1'b1;
                        q_wr_front = link_clamped[NW-1:0];
                    end
                    // The freed node goes on top of the free list.
                    link_we         = 1'b1;
                    link_waddr      = q_front;
                    link_wdata      = free_head_reg;
                    free_head_next  = LW'(q_front);
                    out_valid_next  = 1'b1;
                    out_status_next = mqllm_pkg::ST_OK;
                    out_addr_next   = data_rdata[AW-1:0];
                    out_size_next   = data_rdata[2*AW-1:AW];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_head_reg     <= LINK_NULL;
            nodes_reached_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            free_head_reg     <= free_head_next;
            nodes_reached_reg <= nodes_reached_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_size_reg   <= out_size_next;
        if (accept)
        begin
            op_reg   <= in_op;
            qid_reg  <= in_qid;
            addr_reg <= in_addr;
            size_reg <= in_size;
            pre_reg  <= pre_next;
            ne_reg   <= nonempty;
        end
    end

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) != S_IDLE)
        else $error("result appeared without an item in progress");

    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= LINK_NULL && nodes_reached_reg <= LINK_NULL)
        else $error("free head or node count out of range");

    a_dequeue_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free)
        |=> m_tvalid && m_tuser == mqllm_pkg::ST_OK && state_reg == S_IDLE)
        else $error("dequeue did not finish with an ok result");

    a_refused_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && pre_reg != mqllm_pkg::ST_OK)
        |-> !link_we && !data_we && !q_wr_en && !flag_set && !flag_clr)
        else $error("refused item changed state");

endmodule

FILE: rtl/mqllm_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read and a read enable. Depends on nothing.
module mqllm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/mqllm_queue_table.sv
// Per-queue state: front/back node indices in a RAM, nonempty flags in
// flip-flops, and the active queue count. Uses mqllm_pkg and mqllm_ram.
module mqllm_queue_table #(
    parameter int QUEUE_COUNT = mqllm_pkg::QUEUE_COUNT_DEF,
    parameter int NW          = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mqllm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [mqllm_pkg::QID_W-1:0]   lookup_qid,
    output logic                          id_ok,
    output logic                          nonempty,
    input  logic                          rd_en,
    output logic [NW-1:0]                 rd_front,
    output logic [NW-1:0]                 rd_back,
    input  logic [mqllm_pkg::QID_W-1:0]   wr_qid,
    input  logic                          wr_en,
    input  logic [NW-1:0]                 wr_front,
    input  logic [NW-1:0]                 wr_back,
    input  logic                          flag_set,
    input  logic                          flag_clr
);

    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    logic [mqllm_pkg::CFG_W-1:0] active_queues_reg;
    logic [QUEUE_COUNT-1:0]      nonempty_reg;
    logic [QW-1:0]               lookup_idx;
    logic [QW-1:0]               wr_idx;
    logic [2*NW-1:0]             rd_entry;

    assign lookup_idx = QW'(lookup_qid);
    assign wr_idx     = QW'(wr_qid);

    assign id_ok = ({1'b0, lookup_qid} < active_queues_reg)
                && (32'(lookup_qid) < 32'(QUEUE_COUNT));
    assign nonempty = nonempty_reg[lookup_idx];

    // Entry layout: back index in the upper half, front index in the lower.
    mqllm_ram #(
        .DEPTH (QUEUE_COUNT),
        .WIDTH (2 * NW),
        .AW    (QW)
    ) u_ends (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata ({wr_back, wr_front}),
        .re    (rd_en),
        .raddr (lookup_idx),
        .rdata (rd_entry)
    );

    assign rd_front = rd_entry[NW-1:0];
    assign rd_back  = rd_entry[2*NW-1:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_queues_reg <= '0;
            nonempty_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_queues_reg <= cfg_wdata;
                // Queues dropped by a smaller count lose their contents.
                for (int q = 0; q < QUEUE_COUNT; q++)
                begin
                    if (32'(q) >= 32'(cfg_wdata))
                    begin
                        nonempty_reg[q] <= 1'b0;
                    end
                end
            end
            if (flag_set)
            begin
                nonempty_reg[wr_idx] <= 1'b1;
            end
            if (flag_clr)
            begin
                nonempty_reg[wr_idx] <= 1'b0;
            end
        end
    end

endmodule

FILE: tb/sv/tb_multi_queue_linked_list_manager.sv
// Self-checking testbench for multi_queue_linked_list_manager: a directed table
// and random enqueue/dequeue traffic, checked against a behavioral queue model.
// Depends on mqllm_pkg and the manager RTL only.
`timescale 1ns / 100ps

module tb_multi_queue_linked_list_manager;

    import mqllm_pkg::*;

    localparam int QUEUES         = QUEUE_COUNT_DEF;
    localparam int NODES          = NODE_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   size;
    } entry_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CFG_W-1:0]   cfg_val;
        logic               op;
        logic [QID_W-1:0]   qid;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  size;
        bit                 typed;
        entry_result_t      want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // queue_id, map_address, map_size, pad
    logic [0:0]            s_tuser;    // op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;    // out_address, out_size
    logic [STATUS_W-1:0]   m_tuser;    // status

    // Shadow copy of the queue manager state.
    logic [9:0]        q_front [QUEUES];
    logic [9:0]        q_back  [QUEUES];
    bit                q_live  [QUEUES];
    logic [10:0]       nd_next [NODES];
    logic [ADDR_W-1:0] nd_addr [NODES];
    logic [ADDR_W-1:0] nd_size [NODES];
    logic [10:0]       free_top;
    logic [10:0]       used_nodes;
    logic [CFG_W-1:0]  active_cnt;

    entry_result_t pending_results[$];
    stim_row_t     directed_rows[$];
    int            errors = 0;
    int            full_seen;
    int            burst_left;
    int            quiet_cycles = 0;
    logic [9:0]    rx_cycle = '0;

    multi_queue_linked_list_manager uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [10:0] link_or_end(logic [10:0] v);
        return (v < NODES) ? v : 11'(NODES);
    endfunction

    function automatic void reset_model();
        for (int q = 0; q < QUEUES; q++)
        begin
            q_live[q] = 1'b0;
        end
        free_top   = 11'(NODES);
        used_nodes = '0;
        active_cnt = '0;
    endfunction

    // Shrinking the active count forgets the dropped queues without freeing nodes.
    function automatic void set_active_queues(logic [CFG_W-1:0] v);
        active_cnt = v;
        for (int q = 0; q < QUEUES; q++)
        begin
            if (q >= v)
            begin
                q_live[q] = 1'b0;
            end
        end
    endfunction

    function automatic entry_result_t compute_queue_op(logic op, logic [QID_W-1:0] qid,
                                                       logic [ADDR_W-1:0] addr,
                                                       logic [ADDR_W-1:0] size);
        entry_result_t r;
        logic [10:0]   n;
        logic [10:0]   nx;
        r.status = ST_OK;
        r.addr   = '0;
        r.size   = '0;
        if (qid >= active_cnt)
        begin
            r.status = ST_BADID;
        end
        else if (op == OP_DEQ)
        begin
            if (!q_live[qid])
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                n      = {1'b0, q_front[qid]};
                r.addr = nd_addr[n[9:0]];
                r.size = nd_size[n[9:0]];
                if (n[9:0] == q_back[qid])
                begin
                    q_live[qid] = 1'b0;
                end
                else
                begin
                    nx = link_or_end(nd_next[n[9:0]]);
                    if (nx >= NODES)
                    begin
                        q_live[qid] = 1'b0;
                    end
                    else
                    begin
                        q_front[qid] = nx[9:0];
                    end
                end
                nd_next[n[9:0]] = link_or_end(free_top);
                free_top        = n;
            end
        end
        else
        begin
            free_top = link_or_end(free_top);
            if (free_top < NODES)
            begin
                n        = free_top;
                free_top = link_or_end(nd_next[n[9:0]]);
            end
            else if (used_nodes < NODES)
            begin
                n          = used_nodes;
                used_nodes = used_nodes + 11'd1;
            end
            else
            begin
                r.status = ST_FULL;
                return r;
            end
            nd_addr[n[9:0]] = addr;
            nd_size[n[9:0]] = size;
            nd_next[n[9:0]] = 11'(NODES);
            if (q_live[qid])
            begin
                nd_next[q_back[qid]] = n;
                q_back[qid]          = n[9:0];
            end
            else
            begin
                q_front[qid] = n[9:0];
                q_back[qid]  = n[9:0];
                q_live[qid]  = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic stim_row_t op_row(logic op, int qid, logic [ADDR_W-1:0] addr,
                                         logic [ADDR_W-1:0] size);
        stim_row_t r;
        r.kind        = ROW_ITEM;
        r.cfg_val     = '0;
        r.op          = op;
        r.qid         = QID_W'(qid);
        r.addr        = addr;
        r.size        = size;
        r.typed       = 1'b0;
        r.want.status = ST_OK;
        r.want.addr   = '0;
        r.want.size   = '0;
        return r;
    endfunction

    function automatic stim_row_t checked_row(logic op, int qid, logic [ADDR_W-1:0] addr,
                                              logic [ADDR_W-1:0] size,
                                              logic [STATUS_W-1:0] st,
                                              logic [ADDR_W-1:0] exp_addr,
                                              logic [ADDR_W-1:0] exp_size);
        stim_row_t r;
        r             = op_row(op, qid, addr, size);
        r.typed       = 1'b1;
        r.want.status = st;
        r.want.addr   = exp_addr;
        r.want.size   = exp_size;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(int v);
        stim_row_t r;
        r         = op_row(OP_ENQ, 0, '0, '0);
        r.kind    = ROW_CFG;
        r.cfg_val = CFG_W'(v);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_wide();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v[ADDR_W-1:0];
    endfunction

    // Drives one item in bursts with random gaps, then records its expected result.
    task automatic send_item(input logic op, input logic [QID_W-1:0] qid,
                             input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] size,
                             input bit typed, input entry_result_t want);
        entry_result_t got;
        logic [1:0]    pad;
        int            gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        pad      = 2'($urandom_range(0, 3));
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pad, size, addr, qid};
        do @(posedge clk); while (!s_tready);
        got = compute_queue_op(op, qid, addr, size);
        if (got.status == ST_FULL)
        begin
            full_seen++;
        end
        pending_results.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_active_queues(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        set_active_queues(v);
    endtask

    // Most traffic goes to a few hot queues so that lists grow deep.
    task automatic random_op(input int enq_pct, input int hot_max);
        entry_result_t none;
        logic          op;
        int            qid;
        none.status = ST_OK;
        none.addr   = '0;
        none.size   = '0;
        op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        qid = ($urandom_range(0, 99) < 25) ? $urandom_range(0, QUEUES - 1)
                                           : $urandom_range(0, hot_max);
        send_item(op, QID_W'(qid), pick_wide(), pick_wide(), 1'b0, none);
    endtask

    task automatic run_random(input int count, input int enq_pct, input int hot_max);
        repeat (count) random_op(enq_pct, hot_max);
    endtask

    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 10'd1;
        case (rx_cycle[8:7])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= (rx_cycle[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        entry_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d", m_tuser);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    errors++;
                end
                if (m_tdata[ADDR_W-1:0] !== exp_r.addr)
                begin
                    $error("out_address: expected %h, got %h", exp_r.addr,
                           m_tdata[ADDR_W-1:0]);
                    errors++;
                end
                if (m_tdata[2*ADDR_W-1:ADDR_W] !== exp_r.size)
                begin
                    $error("out_size: expected %h, got %h", exp_r.size,
                           m_tdata[2*ADDR_W-1:ADDR_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;
        int        fill_tries;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        full_seen    = 0;
        burst_left   = 0;
        fill_tries   = 0;
        reset_model();

        // No queue is registered right after reset.
        directed_rows.push_back(checked_row(OP_ENQ, 0, '0, '0, ST_BADID, '0, '0));
        directed_rows.push_back(checked_row(OP_DEQ, 63, '0, '0, ST_BADID, '0, '0));
        directed_rows.push_back(cfg_row(64));
        directed_rows.push_back(checked_row(OP_DEQ, 0, '0, '0, ST_EMPTY, '0, '0));
        directed_rows.push_back(checked_row(OP_ENQ, 0, '1, '1, ST_OK, '0, '0));
        directed_rows.push_back(checked_row(OP_ENQ, 63, '0, '0, ST_OK, '0, '0));
        directed_rows.push_back(checked_row(OP_ENQ, 0, 48'h5555_5555_5555,
                                            48'hAAAA_AAAA_AAAA, ST_OK, '0, '0));
        directed_rows.push_back(checked_row(OP_DEQ, 0, '0, '0, ST_OK, '1, '1));
        directed_rows.push_back(op_row(OP_DEQ, 0, '0, '0));
        directed_rows.push_back(checked_row(OP_DEQ, 0, '0, '0, ST_EMPTY, '0, '0));
        directed_rows.push_back(op_row(OP_ENQ, 40, 48'h1234_5678_9ABC, 48'h1000));
        // Dropping queues 40 and 63 leaves their nodes allocated.
        directed_rows.push_back(cfg_row(10));
        directed_rows.push_back(checked_row(OP_DEQ, 40, '0, '0, ST_BADID, '0, '0));
        directed_rows.push_back(op_row(OP_ENQ, 9, 48'hFEDC_BA98_7654, 48'h0000_0000_0001));
        directed_rows.push_back(checked_row(OP_ENQ, 10, '1, '1, ST_BADID, '0, '0));
        directed_rows.push_back(cfg_row(64));
        directed_rows.push_back(checked_row(OP_DEQ, 40, '0, '0, ST_EMPTY, '0, '0));
        directed_rows.push_back(checked_row(OP_DEQ, 63, '0, '0, ST_EMPTY, '0, '0));
        directed_rows.push_back(op_row(OP_DEQ, 9, '0, '0));
        directed_rows.push_back(cfg_row(1));
        directed_rows.push_back(op_row(OP_ENQ, 0, 48'h8000_0000_0001, 48'h8000_0000_0000));
        directed_rows.push_back(checked_row(OP_ENQ, 1, '0, '0, ST_BADID, '0, '0));
        directed_rows.push_back(op_row(OP_DEQ, 0, '0, '0));
        directed_rows.push_back(checked_row(OP_DEQ, 0, '0, '0, ST_EMPTY, '0, '0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.kind == ROW_CFG)
            begin
                write_active_queues(r.cfg_val);
            end
            else
            begin
                send_item(r.op, r.qid, r.addr, r.size, r.typed, r.want);
            end
        end

        write_active_queues(7'd64);
        run_random(30, 65, 7);
        drain_results();
        run_random(30, 65, 7);

        write_active_queues(7'd5);
        run_random(30, 50, 4);

        // Fill the pool until enqueues are refused a few times, then churn near full.
        write_active_queues(7'd64);
        while (full_seen < 8 && fill_tries < 2 * NODES)
        begin
            random_op(100, QUEUES - 1);
            fill_tries++;
        end
        run_random(30, 50, QUEUES - 1);

        drain_results();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mqllm_pkg.sv
rtl/mqllm_ram.sv
rtl/mqllm_queue_table.sv
rtl/multi_queue_linked_list_manager.sv
tb/sv/tb_multi_queue_linked_list_manager.sv
